// ----- hw/rtl/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
// Used by ile_cell, indexed_list_engine_core, ile_list_checker and testbench. No other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    // Field widths of the request and response
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // List size limits; the control position covers the largest list
    localparam int CAPACITY_DEFAULT = 64;
    localparam int CAPACITY_MAX     = 1024;
    localparam int CTRL_POS_W       = $clog2(CAPACITY_MAX + 1);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_GET  = 3'd0,
        CMD_HEAD = 3'd1,
        CMD_TAIL = 3'd2,
        CMD_AT   = 3'd3,
        CMD_DEL  = 3'd4
    } cmd_e;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic                     load;   // a request is accepted this cycle
        logic                     ins;    // shift up from pos, write value at pos
        logic                     del;    // shift down from pos
        logic                     rd;     // capture the entry at pos
        logic [CTRL_POS_W-1:0]    pos;
        logic [DATA_W-1:0]        value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ile_cell.sv -----
// One storage cell of the list chain: holds one entry and its read term.
// Depends on ile_pkg for the control struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module ile_cell #(
    parameter int IDX = 0
) (
    input  wire logic                     clk,
    input  wire ile_pkg::cell_ctrl_t      ctrl,
    input  wire logic [ile_pkg::DATA_W-1:0] prev_value,
    input  wire logic [ile_pkg::DATA_W-1:0] next_value,
    output logic [ile_pkg::DATA_W-1:0]    value,
    output logic [ile_pkg::DATA_W-1:0]    rd_term
);

    localparam logic [ile_pkg::CTRL_POS_W-1:0] MY_IDX = ile_pkg::CTRL_POS_W'(IDX);

    logic [ile_pkg::DATA_W-1:0] value_reg;
    logic [ile_pkg::DATA_W-1:0] value_next;
    logic [ile_pkg::DATA_W-1:0] rd_term_reg;
    logic [ile_pkg::DATA_W-1:0] rd_term_next;
    logic                       at_pos;
    logic                       above_pos;

    assign at_pos    = (MY_IDX == ctrl.pos);
    assign above_pos = (MY_IDX > ctrl.pos);

    // Entry update: insert pulls from the lower neighbor, delete from the upper
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (at_pos)
                value_next = ctrl.value;
            else if (above_pos)
                value_next = prev_value;
        end
        else if (ctrl.del)
        begin
            if (at_pos || above_pos)
                value_next = next_value;
        end
    end

    // Read term, set on each accepted request: this cell's entry when it is the one asked for, else zero
    always_comb
    begin
        rd_term_next = rd_term_reg;
        if (ctrl.load)
            rd_term_next = (ctrl.rd && at_pos) ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        rd_term_reg <= rd_term_next;
    end

    assign value   = value_reg;
    assign rd_term = rd_term_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_list_engine_core.sv -----
// Top level of the indexed list engine: command decode, count, cell chain
// and response pipe. Depends on ile_pkg and ile_cell.
`timescale 1ns / 1ps
`default_nettype none

//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  request | req_valid | req_stall | req (cmd, position, value)
//  respond | rsp_valid | rsp_stall | rsp (read_value, status, count)
//
// One request per cycle sustained while rsp_stall is low; a request passes the
// decode stage, then the response register, which takes the OR over the cells'
// read terms. The whole cell row shifts in the accept cycle, so inserts and
// deletes cost no more than gets. Reset clears the count and the pipe valids
// only; cell contents stay unknown until written. A stalled response holds the
// pipe, and req_stall rises once both stages are occupied and rsp_stall is high.
module indexed_list_engine_core #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ile_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ile_pkg::rsp_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        s1_valid_reg;
    logic                        s1_get_ok_reg;
    logic                        s1_get_bad_reg;
    logic [ile_pkg::STATUS_W-1:0] s1_status_reg;
    logic [CNT_W-1:0]            s1_count_reg;
    logic                        rsp_valid_reg;
    ile_pkg::rsp_t               rsp_reg;

    logic                        accept;
    logic                        out_load;
    logic                        s1_move;
    logic                        full;
    logic [CMP_W-1:0]            pos_ext;
    logic [CMP_W-1:0]            cnt_ext;
    logic                        get_ok;
    logic                        get_bad;
    logic [ile_pkg::STATUS_W-1:0] status_d;
    ile_pkg::cell_ctrl_t         ctrl;
    logic [ile_pkg::DATA_W-1:0]  cell_value [CAPACITY];
    logic [ile_pkg::DATA_W-1:0]  cell_rd    [CAPACITY];
    logic [ile_pkg::DATA_W-1:0]  rd_or;

    // Pipe handshake
    assign out_load  = !rsp_valid_reg || !rsp_stall;
    assign s1_move   = s1_valid_reg && out_load;
    assign req_stall = s1_valid_reg && !out_load;
    assign accept    = req_valid && !req_stall;

    assign full    = (count_reg == CNT_FULL);
    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);

    // Command decode
    always_comb
    begin
        ctrl       = '0;
        ctrl.load  = accept;
        ctrl.value = req.value;
        get_ok     = 1'b0;
        get_bad    = 1'b0;
        status_d   = ile_pkg::ST_OK;
        count_next = count_reg;
        unique case (req.cmd)
            ile_pkg::CMD_GET:
            begin
                if (pos_ext < cnt_ext)
                begin
                    get_ok   = 1'b1;
                    ctrl.rd  = accept;
                    ctrl.pos = ile_pkg::CTRL_POS_W'(req.position);
                end
                else
                begin
                    get_bad  = 1'b1;
                    status_d = ile_pkg::ST_RANGE;
                end
            end
            ile_pkg::CMD_HEAD:
            begin
                if (full)
                    status_d = ile_pkg::ST_FULL;
                else
                begin
                    ctrl.ins   = accept;
                    ctrl.pos   = '0;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_TAIL:
            begin
                if (full)
                    status_d = ile_pkg::ST_FULL;
                else
                begin
                    ctrl.ins   = accept;
                    ctrl.pos   = ile_pkg::CTRL_POS_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_AT:
            begin
                if (pos_ext > cnt_ext)
                    status_d = ile_pkg::ST_RANGE;
                else if (full)
                    status_d = ile_pkg::ST_FULL;
                else
                begin
                    ctrl.ins   = accept;
                    ctrl.pos   = ile_pkg::CTRL_POS_W'(req.position);
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_DEL:
            begin
                if (pos_ext >= cnt_ext)
                    status_d = ile_pkg::ST_RANGE;
                else
                begin
                    ctrl.del   = accept;
                    ctrl.pos   = ile_pkg::CTRL_POS_W'(req.position);
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_d = ile_pkg::ST_OK;
            end
        endcase
    end

    // Cell chain: each cell sees both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ile_pkg::DATA_W-1:0] prev_v;
        logic [ile_pkg::DATA_W-1:0] next_v;

        if (i == 0)
        begin : g_first
            assign prev_v = '0;
        end
        else
        begin : g_mid_lo
            assign prev_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_v = '0;
        end
        else
        begin : g_mid_hi
            assign next_v = cell_value[i+1];
        end

        ile_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (cell_value[i]),
            .rd_term    (cell_rd[i])
        );
    end

    // Combine read terms; at most one cell is nonzero
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | cell_rd[i];
    end

    // Count and decode stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_get_ok_reg  <= get_ok;
            s1_get_bad_reg <= get_bad;
            s1_status_reg  <= status_d;
            s1_count_reg   <= count_next;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_load)
            rsp_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            if (s1_get_ok_reg)
                rsp_reg.read_value <= rd_or;
            else if (s1_get_bad_reg)
                rsp_reg.read_value <= '1;
            else
                rsp_reg.read_value <= '0;
            rsp_reg.status <= s1_status_reg;
            rsp_reg.count  <= ile_pkg::COUNT_W'(s1_count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- tb/ile_list_checker.sv -----
`timescale 1ns / 1ps
// Checker for indexed_list_engine_core: watches both channels, predicts each
// response from its own copy of the list and compares it field by field.
// Depends on ile_pkg only.
module ile_list_checker #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire ile_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire ile_pkg::rsp_t rsp,
    output int                 fail_count,
    output int                 outstanding
);
    import ile_pkg::*;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int   list_len   = 0;
    int   mismatches = 0;
    rsp_t predicted_results [$];

    // open a slot at p by moving the tail up one place
    function automatic void insert_entry(int p, logic signed [DATA_W-1:0] v);
        for (int i = list_len; i > p; i--)
            list_mem[i] = list_mem[i - 1];
        list_mem[p] = v;
        list_len++;
    endfunction

    // apply one request to the local list and return the response it gives
    function automatic rsp_t apply_list_command(req_t r);
        rsp_t res;
        int   p;
        res        = '0;
        res.status = ST_OK;
        p          = int'(r.position);
        case (r.cmd)
            CMD_GET:
                if (p < list_len)
                    res.read_value = list_mem[p];
                else
                begin
                    res.read_value = -1;
                    res.status     = ST_RANGE;
                end
            CMD_HEAD, CMD_TAIL:
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                    insert_entry((r.cmd == CMD_HEAD) ? 0 : list_len, r.value);
            CMD_AT:
                // range check wins over full
                if (p > list_len)
                    res.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                    insert_entry(p, r.value);
            CMD_DEL:
                if (p >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            default:
                ;  // spare codes leave the list alone
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    // 4-state compare so an X on a response field counts as a mismatch
    function automatic void check_field(string field, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, want, got);
        end
    endfunction

    // predict on each accepted request, compare on each accepted response
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        if (!rst_n)
        begin
            predicted_results.delete();
            list_len = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predicted_results.push_back(apply_list_command(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response mismatch, expected none, got %0d/%0d/%0d",
                             $time, rsp.read_value, rsp.status, rsp.count);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("status", want.status, rsp.status);
                    check_field("count", want.count, rsp.count);
                end
            end
        end
        fail_count  <= mismatches;
        outstanding <= predicted_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the indexed list engine testbench: clock, reset, request stimulus,
// response stall pattern, watchdog and verdict.
// Depends on ile_pkg, indexed_list_engine_core and ile_list_checker.
module testbench;
    import ile_pkg::*;

    localparam int LIST_CAPACITY  = CAPACITY_DEFAULT;
    localparam int RANDOM_REQS    = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // command codes the block does not decode
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_e;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   outstanding;

    // stimulus state: list length as the requests will leave it
    int        shadow_len  = 0;
    mix_mode_e phase_mode  = MODE_GROW;
    int        phase_left  = 160;
    req_t      opening_reqs [$];

    // receiver pattern and watchdog
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_tick  = 0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    indexed_list_engine_core #(.CAPACITY(LIST_CAPACITY)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    ile_list_checker #(.CAPACITY(LIST_CAPACITY)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // list length after a request; used only to aim positions
    function automatic int next_length(req_t r, int len);
        case (r.cmd)
            CMD_HEAD, CMD_TAIL:
                if (len < LIST_CAPACITY)
                    return len + 1;
            CMD_AT:
                if (int'(r.position) <= len && len < LIST_CAPACITY)
                    return len + 1;
            CMD_DEL:
                if (int'(r.position) < len)
                    return len - 1;
            default:
                ;
        endcase
        return len;
    endfunction

    function automatic void add_opening(logic [CMD_W-1:0] c, int p,
                                        logic [DATA_W-1:0] v);
        req_t r;
        r.cmd      = c;
        r.position = POS_W'(p);
        r.value    = v;
        opening_reqs.push_back(r);
        shadow_len = next_length(r, shadow_len);
    endfunction

    // random request, biased by phase so the list fills up and drains
    function automatic req_t random_request();
        req_t r;
        int   roll;
        int   pos;
        int   ins_lim;
        int   get_lim;
        if (phase_left == 0)
        begin
            phase_mode = mix_mode_e'($urandom_range(2));
            phase_left = $urandom_range(40, 200);
        end
        phase_left--;
        case (phase_mode)
            MODE_GROW:
            begin
                ins_lim = 62;
                get_lim = 82;
            end
            MODE_SHRINK:
            begin
                ins_lim = 20;
                get_lim = 45;
            end
            default:
            begin
                ins_lim = 35;
                get_lim = 65;
            end
        endcase

        roll = $urandom_range(99);
        if (roll < ins_lim)
            r.cmd = CMD_W'($urandom_range(CMD_HEAD, CMD_AT));
        else if (roll < get_lim)
            r.cmd = CMD_GET;
        else if (roll < 97)
            r.cmd = CMD_DEL;
        else
            r.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

        // mostly legal positions, some at the edges, some anywhere
        roll = $urandom_range(99);
        if (roll < 12)
            pos = $urandom_range(0, LIST_CAPACITY);
        else if (roll < 20)
            case ($urandom_range(3))
                0:       pos = shadow_len;
                1:       pos = (shadow_len < LIST_CAPACITY) ? shadow_len + 1 : shadow_len;
                2:       pos = LIST_CAPACITY;
                default: pos = 0;
            endcase
        else if (r.cmd == CMD_AT)
            pos = $urandom_range(0, shadow_len);
        else
            pos = (shadow_len == 0) ? 0 : $urandom_range(0, shadow_len - 1);
        r.position = POS_W'(pos);

        if ($urandom_range(99) < 15)
            case ($urandom_range(3))
                0:       r.value = 32'h8000_0000;
                1:       r.value = 32'h7fff_ffff;
                2:       r.value = '1;
                default: r.value = '0;
            endcase
        else
            r.value = $urandom;

        shadow_len = next_length(r, shadow_len);
        return r;
    endfunction

    // request side: bursts and gaps, payload held while stalled
    initial
    begin
        int sent;
        int issued;
        int total;
        int burst_left;
        int gap_left;
        int roll;

        // empty list corners
        add_opening(CMD_GET, 0, $urandom);
        add_opening(CMD_GET, LIST_CAPACITY, $urandom);
        add_opening(CMD_DEL, 0, $urandom);
        add_opening(CMD_AT, 1, $urandom);
        // position 0 on an empty list, then every insert kind
        add_opening(CMD_AT, 0, 32'h7fff_ffff);
        add_opening(CMD_HEAD, 5, 32'h8000_0000);
        add_opening(CMD_TAIL, 9, '1);
        add_opening(CMD_AT, 3, '0);              // position equal to count appends
        add_opening(CMD_AT, 0, 32'h5555_5555);   // position 0 of a longer list
        add_opening(CMD_AT, 2, 32'haaaa_aaaa);
        add_opening(CMD_AT, 7, $urandom);        // past the end
        // reads at first, last and beyond
        add_opening(CMD_GET, 0, $urandom);
        add_opening(CMD_GET, 5, $urandom);
        add_opening(CMD_GET, 6, $urandom);
        add_opening(CMD_GET, LIST_CAPACITY, $urandom);
        // deletes past the end, at the end, at the head, in the middle
        add_opening(CMD_DEL, 6, $urandom);
        add_opening(CMD_DEL, 5, $urandom);
        add_opening(CMD_DEL, 0, $urandom);
        add_opening(CMD_DEL, 1, $urandom);
        // spare command codes
        add_opening(CMD_SPARE_LO, LIST_CAPACITY, $urandom);
        add_opening(CMD_SPARE_LO + 3'd1, 1, '1);
        add_opening(CMD_SPARE_HI, 0, 32'h8000_0000);

        sent       = 0;
        issued     = 0;
        total      = opening_reqs.size() + RANDOM_REQS;
        burst_left = $urandom_range(1, 40);
        gap_left   = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (sent < total)
        begin
            @(posedge clk);
            if (req_valid && !req_stall)
                sent++;
            if (!(req_valid && req_stall))
            begin
                if (issued == total || gap_left > 0)
                begin
                    req_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    req       <= (issued < opening_reqs.size()) ? opening_reqs[issued]
                                                                : random_request();
                    req_valid <= 1'b1;
                    issued++;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        roll       = $urandom_range(99);
                        if (roll < 25)
                            gap_left = 0;
                        else if (roll < 95)
                            gap_left = $urandom_range(1, 6);
                        else
                            gap_left = $urandom_range(10, 30);
                    end
                end
            end
        end

        // drain the responses, then let the pipe settle
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // response side: stall pattern drawn at random from four modes
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(3);
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(99) < 30);
            2:       rsp_stall <= ($urandom_range(99) < 70);
            default: rsp_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // watchdog: too long without any request or response taken
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- sim.f -----
hw/rtl/ile_pkg.sv
hw/rtl/ile_cell.sv
hw/rtl/indexed_list_engine_core.sv
tb/ile_list_checker.sv
tb/testbench.sv
